// ----- rtl/qrm_pkg.sv -----
// ----------------------------------------------------------------------------
// qrm_pkg
// shared constants and types for the quaternion to rotation matrix pipeline
// ----------------------------------------------------------------------------
package qrm_pkg;

  // number of matrix entries
  localparam int unsigned NumEntries = 9;

  // entry index codes
  typedef enum logic [3:0] {
    E00 = 4'd0, E01 = 4'd1, E02 = 4'd2,
    E10 = 4'd3, E11 = 4'd4, E12 = 4'd5,
    E20 = 4'd6, E21 = 4'd7, E22 = 4'd8
  } entry_e;

endpackage

// ----- rtl/qrm_div.sv -----
// ----------------------------------------------------------------------------
// qrm_div
// pipelined restoring divider: one quotient bit per stage, nine entries wide
// ----------------------------------------------------------------------------
module qrm_div import qrm_pkg::*; #(
  parameter int unsigned NumW  = 35,
  parameter int unsigned QBits = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [NumEntries-1:0]             sign_i,
  input  logic [NumEntries-1:0][NumW-1:0]   num_i,
  input  logic [NumW-1:0]                   den_i,
  input  logic                              degen_i,
  output logic                              valid_o,
  output logic [NumEntries-1:0]             sign_o,
  output logic [NumEntries-1:0][QBits-1:0]  quo_o,
  output logic                              degen_o
);

  // per stage: remainder, quotient, den, sign, degenerate, valid
  logic [QBits-1:0]                           vld_q;
  logic [QBits-1:0][NumEntries-1:0][NumW:0]   rem_q;
  logic [QBits-1:0][NumEntries-1:0][QBits-1:0] quo_q;
  logic [QBits-1:0][NumW-1:0]                 den_q;
  logic [QBits-1:0][NumEntries-1:0]           sgn_q;
  logic [QBits-1:0]                           dg_q;

  logic [QBits-1:0][NumEntries-1:0][NumW:0]   rem_d;
  logic [QBits-1:0][NumEntries-1:0][QBits-1:0] quo_d;

  // stage 0 takes the integer bit, later stages shift and compare
  always_comb begin
    for (int s = 0; s < QBits; s++) begin
      for (int e = 0; e < NumEntries; e++) begin
        logic [NumW:0] r;
        logic [NumW:0] dd;
        if (s == 0) begin
          r = {1'b0, num_i[e]};
          dd = {1'b0, den_i};
          quo_d[s][e] = '0;
        end else begin
          r = {rem_q[s-1][e][NumW-1:0], 1'b0};
          dd = {1'b0, den_q[s-1]};
          quo_d[s][e] = {quo_q[s-1][e][QBits-2:0], 1'b0};
        end
        if (r >= dd) begin
          rem_d[s][e] = r - dd;
          quo_d[s][e][0] = 1'b1;
        end else begin
          rem_d[s][e] = r;
        end
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QBits-2:0], valid_i};
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < QBits; s++) begin
        rem_q[s] <= rem_d[s];
        quo_q[s] <= quo_d[s];
        if (s == 0) begin
          den_q[s] <= den_i;
          sgn_q[s] <= sign_i;
          dg_q[s]  <= degen_i;
        end else begin
          den_q[s] <= den_q[s-1];
          sgn_q[s] <= sgn_q[s-1];
          dg_q[s]  <= dg_q[s-1];
        end
      end
    end
  end

  assign valid_o = vld_q[QBits-1];
  assign sign_o  = sgn_q[QBits-1];
  assign quo_o   = quo_q[QBits-1];
  assign degen_o = dg_q[QBits-1];

endmodule

// ----- rtl/quaternion_to_rotation_matrix_top.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_top
// quaternion (w, x, y, z) to normalized 3x3 rotation matrix
// ----------------------------------------------------------------------------
// Fully pipelined: one quaternion is taken every cycle unless the output
// is stalled. Each transaction passes through OUT_WIDTH+4 register stages (a
// sign and magnitude stage, a product stage, a sum stage, one quotient-bit
// stage per output bit, a rounding stage). Most of these stages belong to
// the bit-per-stage divider that divides every numerator by the squared
// norm. A stall at the output freezes the whole pipeline; the input is taken
// whenever the output register is free or draining.
module quaternion_to_rotation_matrix_top import qrm_pkg::*; #(
  parameter int unsigned IN_WIDTH  = 16,
  parameter int unsigned OUT_WIDTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  logic signed [IN_WIDTH-1:0]  quat_w_i,
  input  logic signed [IN_WIDTH-1:0]  quat_x_i,
  input  logic signed [IN_WIDTH-1:0]  quat_y_i,
  input  logic signed [IN_WIDTH-1:0]  quat_z_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output logic signed [OUT_WIDTH-1:0] m00_o,
  output logic signed [OUT_WIDTH-1:0] m01_o,
  output logic signed [OUT_WIDTH-1:0] m02_o,
  output logic signed [OUT_WIDTH-1:0] m10_o,
  output logic signed [OUT_WIDTH-1:0] m11_o,
  output logic signed [OUT_WIDTH-1:0] m12_o,
  output logic signed [OUT_WIDTH-1:0] m20_o,
  output logic signed [OUT_WIDTH-1:0] m21_o,
  output logic signed [OUT_WIDTH-1:0] m22_o,
  output logic                        degenerate_o
);

  localparam int unsigned MagW  = IN_WIDTH;
  localparam int unsigned PrW   = 2 * IN_WIDTH;
  localparam int unsigned NumW  = PrW + 3;
  localparam int unsigned FracW = OUT_WIDTH - 2;
  localparam int unsigned QBits = FracW + 2;

  // pipeline advances unless a held result is stalled
  logic en;
  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;

  // stage 1: magnitudes and signs
  logic          v1_q;
  logic [3:0]    n1_q;
  logic [3:0][MagW-1:0] m1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      n1_q <= {quat_z_i[IN_WIDTH-1], quat_y_i[IN_WIDTH-1],
               quat_x_i[IN_WIDTH-1], quat_w_i[IN_WIDTH-1]};
      m1_q[0] <= quat_w_i[IN_WIDTH-1] ? MagW'(-quat_w_i) : MagW'(quat_w_i);
      m1_q[1] <= quat_x_i[IN_WIDTH-1] ? MagW'(-quat_x_i) : MagW'(quat_x_i);
      m1_q[2] <= quat_y_i[IN_WIDTH-1] ? MagW'(-quat_y_i) : MagW'(quat_y_i);
      m1_q[3] <= quat_z_i[IN_WIDTH-1] ? MagW'(-quat_z_i) : MagW'(quat_z_i);
    end
  end

  // stage 2: squares and pairwise products (w0 x1 y2 z3)
  logic          v2_q;
  logic [3:0]    n2_q;
  logic [3:0][PrW-1:0] sq2_q;
  logic [PrW-1:0] xy_q, zw_q, xz_q, yw_q, yz_q, xw_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      n2_q <= n1_q;
      for (int i = 0; i < 4; i++) sq2_q[i] <= m1_q[i] * m1_q[i];
      xy_q <= m1_q[1] * m1_q[2];
      zw_q <= m1_q[3] * m1_q[0];
      xz_q <= m1_q[1] * m1_q[3];
      yw_q <= m1_q[2] * m1_q[0];
      yz_q <= m1_q[2] * m1_q[3];
      xw_q <= m1_q[1] * m1_q[0];
    end
  end

  // stage 3: numerators in sign-magnitude and the squared norm
  logic [NumEntries-1:0]           s3_d;
  logic [NumEntries-1:0][NumW-1:0] num3_d;
  logic [NumW-1:0]                 den3_d;

  function automatic logic [NumW:0] sm_add(input logic sa, input logic [NumW-1:0] a,
                                           input logic sb, input logic [NumW-1:0] b);
    logic          s;
    logic [NumW-1:0] m;
    if (sa == sb) begin
      m = a + b;
      s = sa;
    end else if (a >= b) begin
      m = a - b;
      s = sa;
    end else begin
      m = b - a;
      s = sb;
    end
    if (m == '0) s = 1'b0;
    return {s, m};
  endfunction

  always_comb begin
    logic [NumW:0] r [NumEntries];
    logic nw, nx, ny, nz;
    nw = n2_q[0]; nx = n2_q[1]; ny = n2_q[2]; nz = n2_q[3];
    den3_d = NumW'(sq2_q[0]) + NumW'(sq2_q[1]) + NumW'(sq2_q[2]) + NumW'(sq2_q[3]);
    r[E00] = sm_add(1'b0, NumW'(sq2_q[1]) + NumW'(sq2_q[0]),
                    1'b1, NumW'(sq2_q[2]) + NumW'(sq2_q[3]));
    r[E11] = sm_add(1'b0, NumW'(sq2_q[2]) + NumW'(sq2_q[0]),
                    1'b1, NumW'(sq2_q[1]) + NumW'(sq2_q[3]));
    r[E22] = sm_add(1'b0, NumW'(sq2_q[3]) + NumW'(sq2_q[0]),
                    1'b1, NumW'(sq2_q[1]) + NumW'(sq2_q[2]));
    r[E01] = sm_add(nx != ny, NumW'(xy_q), nz == nw, NumW'(zw_q));
    r[E10] = sm_add(nx != ny, NumW'(xy_q), nz != nw, NumW'(zw_q));
    r[E02] = sm_add(nx != nz, NumW'(xz_q), ny != nw, NumW'(yw_q));
    r[E20] = sm_add(nx != nz, NumW'(xz_q), ny == nw, NumW'(yw_q));
    r[E12] = sm_add(ny != nz, NumW'(yz_q), nx == nw, NumW'(xw_q));
    r[E21] = sm_add(ny != nz, NumW'(yz_q), nx != nw, NumW'(xw_q));
    for (int e = 0; e < NumEntries; e++) begin
      s3_d[e] = r[e][NumW];
      // off-diagonal entries carry the factor of two
      if (e == E00 || e == E11 || e == E22) num3_d[e] = r[e][NumW-1:0];
      else num3_d[e] = {r[e][NumW-2:0], 1'b0};
    end
  end

  logic                            v3_q;
  logic [NumEntries-1:0]           s3_q;
  logic [NumEntries-1:0][NumW-1:0] num3_q;
  logic [NumW-1:0]                 den3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q   <= s3_d;
      num3_q <= num3_d;
      den3_q <= den3_d;
    end
  end

  // quotient bits, one per stage
  logic                             vq;
  logic [NumEntries-1:0]            sq;
  logic [NumEntries-1:0][QBits-1:0] qq;
  logic                             dq;
  qrm_div #(.NumW(NumW), .QBits(QBits)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .sign_i  (s3_q),
    .num_i   (num3_q),
    .den_i   (den3_q),
    .degen_i (den3_q == '0),
    .valid_o (vq),
    .sign_o  (sq),
    .quo_o   (qq),
    .degen_o (dq)
  );

  // round half away, clamp, apply sign; identity on zero norm
  logic [NumEntries-1:0][OUT_WIDTH-1:0] res_d, res_q;
  logic                                 deg_q;
  always_comb begin
    for (int e = 0; e < NumEntries; e++) begin
      logic [QBits-1:0] r;
      r = (qq[e] + QBits'(1)) >> 1;
      if (r > QBits'(1) << FracW) r = QBits'(1) << FracW;
      if (dq) begin
        res_d[e] = (e == E00 || e == E11 || e == E22) ?
                   OUT_WIDTH'(1) << FracW : '0;
      end else begin
        res_d[e] = sq[e] ? OUT_WIDTH'(-r) : OUT_WIDTH'(r);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= vq;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
      deg_q <= dq;
    end
  end

  assign m00_o = res_q[E00];
  assign m01_o = res_q[E01];
  assign m02_o = res_q[E02];
  assign m10_o = res_q[E10];
  assign m11_o = res_q[E11];
  assign m12_o = res_q[E12];
  assign m20_o = res_q[E20];
  assign m21_o = res_q[E21];
  assign m22_o = res_q[E22];
  assign degenerate_o = deg_q;

  // a degenerate result carries the identity matrix
  a_degen_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && degenerate_o |-> m00_o == OUT_WIDTH'(1) << FracW && m01_o == '0)
    else $error("degenerate result is not identity");

  // stall freezes the output register
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(m00_o) && $stable(m12_o))
    else $error("stalled result changed");

  // the m11 entry stays within plus or minus one
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $signed(m11_o) <= $signed(OUT_WIDTH'(1) << FracW)
             && $signed(m11_o) >= -$signed(OUT_WIDTH'(1) << FracW))
    else $error("entry out of range");

endmodule
